// ===== design/sia_pkg.sv =====
// Shared types and constants for the salience ignition arbiter.
// No dependencies; compiled first.

package sia_pkg;

   localparam int NUM_REGIONS = 16;
   localparam int RIDX_W      = $clog2(NUM_REGIONS);
   localparam int CNT_W       = $clog2(NUM_REGIONS + 1);

   localparam int REGION_W    = 4;
   localparam int TIME_W      = 32;
   localparam int SAL_W       = 32;
   localparam int PEND_W      = 16;
   localparam int HALF_W      = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int PROD_W      = SAL_W + HALF_W;
   localparam int QUO_W       = 32;
   localparam int DIV_CNT_W   = $clog2(QUO_W);

   localparam logic [HALF_W-1:0] DECAY_RST     = 16'd58982;
   localparam logic [HALF_W-1:0] MIN_GAP_RST   = 16'd10;
   localparam logic [SAL_W-1:0]  THRESHOLD_RST = 32'd5120;
   localparam logic [HALF_W-1:0] BURST_LEN_RST = 16'd10;
   localparam logic [HALF_W-1:0] BURST_GAIN_RST = 16'd512;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DECAY_FACTOR,
      CSR_MIN_GAP_TICKS,
      CSR_IGNITE_THRESHOLD,
      CSR_BURST_LENGTH,
      CSR_BURST_GAIN
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DECIDE,
      ST_GAIN,
      ST_DMUL,
      ST_DSTART,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [HALF_W-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_stat_type;

endpackage

// ===== design/sia_if.sv =====
// Request and response channel interfaces for the salience ignition arbiter.
// Depends on sia_pkg for field widths.

interface sia_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [sia_pkg::REGION_W-1:0]  region_index;
   logic [sia_pkg::TIME_W-1:0]    time_now;

   modport source (output valid, cmd, region_index, time_now, input ready);
   modport sink   (input valid, cmd, region_index, time_now, output ready);
endinterface

interface sia_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sia_pkg::SAL_W-1:0]     drive_level;
   logic                          ignited;
   logic [sia_pkg::REGION_W-1:0]  content_region;
   logic [sia_pkg::REGION_W-1:0]  winner_region;
   logic [sia_pkg::SAL_W-1:0]     winning_salience;
   logic [sia_pkg::SAL_W-1:0]     ignition_total;
   logic [sia_pkg::HALF_W-1:0]    burst_left;

   modport source (output valid, drive_level, ignited, content_region, winner_region,
                   winning_salience, ignition_total, burst_left, input ready);
   modport sink   (input valid, drive_level, ignited, content_region, winner_region,
                   winning_salience, ignition_total, burst_left, output ready);
endinterface

// ===== design/salience_ignition_arbiter_top.sv =====
// Salience ignition arbiter top level: region salience, winner pick and broadcast.
// Depends on sia_pkg, sia_if (sia_req_if, sia_rsp_if) and sia_divider.

// A spike request is taken while idle and produces no response; ready stays high.
// A tick request walks the regions through one shared 32x16 multiplier, one region
// a cycle, then decides on ignition and computes the drive with the same multiplier
// and a one-bit-a-cycle divider. Ready is low from a tick until the sequencer is
// idle again. A tick that leaves no broadcast to drive skips the divider; an
// ignition adds a gain step, and a drive whose quotient would not fit saturates
// at once in the divider instead of stepping bit by bit. The done state holds
// while the previous response is still waiting. A finished response waits in an
// output register, so spikes keep flowing while it is not yet taken. No clearing
// pass is needed after reset.

module salience_ignition_arbiter_top (
   input  logic                            clock,
   input  logic                            reset,
   sia_req_if.sink                         req_ch,
   sia_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [sia_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sia_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int N      = sia_pkg::NUM_REGIONS;
   localparam int RIDX_W = sia_pkg::RIDX_W;
   localparam int CNT_W  = sia_pkg::CNT_W;
   localparam int SAL_W  = sia_pkg::SAL_W;
   localparam int HALF_W = sia_pkg::HALF_W;
   localparam int PROD_W = sia_pkg::PROD_W;
   localparam int PEND_W = sia_pkg::PEND_W;

   // configuration
   logic [HALF_W-1:0] decay_ff, min_gap_ff, burst_len_ff, burst_gain_ff;
   logic [SAL_W-1:0]  threshold_ff;

   // region state
   logic [SAL_W-1:0]  sal_ff  [N];
   logic [PEND_W-1:0] pend_ff [N];

   // sequencer and datapath
   sia_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic               prod_vld_ff;
   logic [RIDX_W-1:0]  acc_idx_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [SAL_W-1:0]   best_ff;
   logic [RIDX_W-1:0]  win_ff;
   logic [sia_pkg::TIME_W-1:0] time_ff;
   logic [SAL_W-1:0]   drive_ff;

   // broadcast state
   logic               is_lit_ff;
   logic [RIDX_W-1:0]  latched_ff;
   logic [HALF_W-1:0]  remaining_ff;
   logic [SAL_W-1:0]   burst_cur_ff;
   logic [sia_pkg::TIME_W-1:0] last_time_ff;
   logic               ever_ff;
   logic [SAL_W-1:0]   counter_ff;

   // response register
   logic                         rsp_valid_ff;
   logic [SAL_W-1:0]             rsp_drive_ff;
   logic                         rsp_ignited_ff;
   logic [sia_pkg::REGION_W-1:0] rsp_content_ff;
   logic [sia_pkg::REGION_W-1:0] rsp_winner_ff;
   logic [SAL_W-1:0]             rsp_best_ff;
   logic [SAL_W-1:0]             rsp_total_ff;
   logic [HALF_W-1:0]            rsp_left_ff;

   // combinational
   logic               req_acc, spike_acc, tick_acc, spike_in_range;
   logic [RIDX_W-1:0]  spike_idx, pend_idx, cnt_idx;
   logic [PEND_W-1:0]  pend_rd;
   logic               sweep_issue, sweep_last;
   logic [SAL_W-1:0]   mul_a;
   logic [HALF_W-1:0]  mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic               mul_en;
   logic [SAL_W:0]     sal_sum;
   logic [SAL_W-1:0]   sal_new;
   logic [sia_pkg::TIME_W-1:0] gap;
   logic               ignite;
   logic [HALF_W-1:0]  eff_len;
   logic [SAL_W-1:0]   gain_sat;
   logic               rsp_free, rsp_load;
   sia_pkg::div_ctrl_type div_ctrl;
   sia_pkg::div_stat_type div_stat;

   assign req_acc        = req_ch.valid && req_ch.ready;
   assign spike_acc      = req_acc && !req_ch.cmd;
   assign tick_acc       = req_acc && req_ch.cmd;
   assign spike_in_range = 32'(req_ch.region_index) < 32'(N);
   assign spike_idx      = RIDX_W'(req_ch.region_index);
   assign cnt_idx        = cnt_ff[RIDX_W-1:0];
   assign sweep_issue    = cnt_ff < CNT_W'(N);
   assign sweep_last     = cnt_ff == CNT_W'(N);

   // single read port on the pending counts
   assign pend_idx = (state_ff == sia_pkg::ST_IDLE) ? spike_idx : acc_idx_ff;
   assign pend_rd  = pend_ff[pend_idx];

   // decayed salience plus pending spikes, saturating
   assign sal_sum = {1'b0, prod_ff[PROD_W-1:HALF_W]} + (SAL_W + 1)'({pend_rd, 8'h00});
   assign sal_new = sal_sum[SAL_W] ? '1 : sal_sum[SAL_W-1:0];

   assign eff_len  = (burst_len_ff == '0) ? HALF_W'(1) : burst_len_ff;
   assign gap      = time_ff - last_time_ff;
   assign ignite   = !is_lit_ff && (!ever_ff || gap >= 32'(min_gap_ff))
                     && best_ff >= threshold_ff;
   assign gain_sat = (|prod_ff[PROD_W-1:SAL_W + 8]) ? '1 : prod_ff[SAL_W + 7:8];
   assign mul_p    = mul_a * mul_b;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sia_pkg::ST_IDLE:   if (tick_acc) state_in = sia_pkg::ST_SWEEP;
         sia_pkg::ST_SWEEP:  if (sweep_last) state_in = sia_pkg::ST_DECIDE;
         sia_pkg::ST_DECIDE: state_in = ignite ? sia_pkg::ST_GAIN : sia_pkg::ST_DMUL;
         sia_pkg::ST_GAIN:   state_in = sia_pkg::ST_DMUL;
         sia_pkg::ST_DMUL: begin
            state_in = (remaining_ff != '0) ? sia_pkg::ST_DSTART : sia_pkg::ST_DONE;
         end
         sia_pkg::ST_DSTART: state_in = sia_pkg::ST_DIV;
         sia_pkg::ST_DIV:    if (div_stat.done) state_in = sia_pkg::ST_DONE;
         sia_pkg::ST_DONE:   if (rsp_free) state_in = sia_pkg::ST_IDLE;
         default:            state_in = sia_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: shared multiplier operands and strobes
   always_comb begin
      mul_a             = '0;
      mul_b             = '0;
      mul_en            = 1'b0;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = prod_ff;
      div_ctrl.divisor  = eff_len;
      rsp_load          = 1'b0;
      req_ch.ready      = 1'b0;
      unique case (state_ff)
         sia_pkg::ST_IDLE: req_ch.ready = 1'b1;
         sia_pkg::ST_SWEEP: begin
            mul_a  = sal_ff[cnt_idx];
            mul_b  = decay_ff;
            mul_en = sweep_issue;
         end
         sia_pkg::ST_DECIDE: begin
            mul_a  = best_ff;
            mul_b  = burst_gain_ff;
            mul_en = 1'b1;
         end
         sia_pkg::ST_GAIN: ;
         sia_pkg::ST_DMUL: begin
            mul_a  = burst_cur_ff;
            mul_b  = remaining_ff;
            mul_en = 1'b1;
         end
         sia_pkg::ST_DSTART: div_ctrl.start = 1'b1;
         sia_pkg::ST_DIV: ;
         sia_pkg::ST_DONE: rsp_load = rsp_free;
         default: ;
      endcase
   end

   sia_divider u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff      <= sia_pkg::DECAY_RST;
         min_gap_ff    <= sia_pkg::MIN_GAP_RST;
         threshold_ff  <= sia_pkg::THRESHOLD_RST;
         burst_len_ff  <= sia_pkg::BURST_LEN_RST;
         burst_gain_ff <= sia_pkg::BURST_GAIN_RST;
      end else if (csr_we) begin
         unique case (sia_pkg::csr_index_type'(csr_index))
            sia_pkg::CSR_DECAY_FACTOR:     decay_ff      <= csr_wdata[HALF_W-1:0];
            sia_pkg::CSR_MIN_GAP_TICKS:    min_gap_ff    <= csr_wdata[HALF_W-1:0];
            sia_pkg::CSR_IGNITE_THRESHOLD: threshold_ff  <= csr_wdata[SAL_W-1:0];
            sia_pkg::CSR_BURST_LENGTH:     burst_len_ff  <= csr_wdata[HALF_W-1:0];
            sia_pkg::CSR_BURST_GAIN:       burst_gain_ff <= csr_wdata[HALF_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer and region / broadcast state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sia_pkg::ST_IDLE;
         cnt_ff       <= '0;
         prod_vld_ff  <= 1'b0;
         is_lit_ff    <= 1'b0;
         latched_ff   <= '0;
         remaining_ff <= '0;
         burst_cur_ff <= '0;
         last_time_ff <= '0;
         ever_ff      <= 1'b0;
         counter_ff   <= '0;
         for (int i = 0; i < N; i++) begin
            sal_ff[i]  <= '0;
            pend_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (spike_acc && spike_in_range && pend_rd != '1) begin
            pend_ff[spike_idx] <= pend_rd + 1'b1;
         end
         if (tick_acc) begin
            cnt_ff      <= '0;
            prod_vld_ff <= 1'b0;
         end
         if (state_ff == sia_pkg::ST_SWEEP) begin
            cnt_ff      <= cnt_ff + 1'b1;
            prod_vld_ff <= sweep_issue;
            if (prod_vld_ff) begin
               sal_ff[acc_idx_ff]  <= sal_new;
               pend_ff[acc_idx_ff] <= '0;
            end
         end
         if (state_ff == sia_pkg::ST_DECIDE && ignite) begin
            is_lit_ff    <= 1'b1;
            latched_ff   <= win_ff;
            counter_ff   <= counter_ff + 1'b1;
            remaining_ff <= eff_len;
            last_time_ff <= time_ff;
            ever_ff      <= 1'b1;
         end
         if (state_ff == sia_pkg::ST_GAIN) begin
            burst_cur_ff <= gain_sat;
         end
         if (state_ff == sia_pkg::ST_DSTART) begin
            remaining_ff <= remaining_ff - 1'b1;
            if (remaining_ff == HALF_W'(1)) begin
               is_lit_ff <= 1'b0;
            end
         end
      end
   end

   // datapath payload
   always_ff @(posedge clock) begin
      if (tick_acc) begin
         time_ff  <= req_ch.time_now;
         best_ff  <= '0;
         win_ff   <= '0;
         drive_ff <= '0;
      end
      if (mul_en) begin
         prod_ff <= mul_p;
      end
      if (state_ff == sia_pkg::ST_SWEEP) begin
         acc_idx_ff <= cnt_idx;
         // strictly greater keeps the lowest index on a tie
         if (prod_vld_ff && sal_new > best_ff) begin
            best_ff <= sal_new;
            win_ff  <= acc_idx_ff;
         end
      end
      if (state_ff == sia_pkg::ST_DIV && div_stat.done) begin
         drive_ff <= div_stat.quotient;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_drive_ff   <= drive_ff;
         rsp_ignited_ff <= is_lit_ff;
         rsp_content_ff <= sia_pkg::REGION_W'(latched_ff);
         rsp_winner_ff  <= sia_pkg::REGION_W'(win_ff);
         rsp_best_ff    <= best_ff;
         rsp_total_ff   <= counter_ff;
         rsp_left_ff    <= remaining_ff;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.drive_level      = rsp_drive_ff;
   assign rsp_ch.ignited          = rsp_ignited_ff;
   assign rsp_ch.content_region   = rsp_content_ff;
   assign rsp_ch.winner_region    = rsp_winner_ff;
   assign rsp_ch.winning_salience = rsp_best_ff;
   assign rsp_ch.ignition_total   = rsp_total_ff;
   assign rsp_ch.burst_left       = rsp_left_ff;

endmodule

// ===== design/sia_divider.sv =====
// Bit-serial restoring divider: 48-bit dividend by 16-bit divisor, 32-bit quotient.
// A quotient that would not fit saturates at once. Depends on sia_pkg.

module sia_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  sia_pkg::div_ctrl_type ctrl,
   output sia_pkg::div_stat_type stat
);

   logic                           busy_ff;
   logic                           done_ff;
   logic [sia_pkg::DIV_CNT_W-1:0]  cnt_ff;
   logic [sia_pkg::HALF_W-1:0]     rem_ff;
   logic [sia_pkg::QUO_W-1:0]      quo_ff;
   logic [sia_pkg::HALF_W-1:0]     dsr_ff;

   logic [sia_pkg::HALF_W:0]       trial;
   logic [sia_pkg::HALF_W:0]       diff;
   logic                           fits;
   logic                           overflow;

   assign trial    = {rem_ff, quo_ff[sia_pkg::QUO_W-1]};
   assign diff     = trial - {1'b0, dsr_ff};
   assign fits     = trial >= {1'b0, dsr_ff};
   // quotient >= 2^32 exactly when the upper dividend bits reach the divisor
   assign overflow = ctrl.dividend[sia_pkg::PROD_W-1:sia_pkg::QUO_W] >= ctrl.divisor;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff <= !overflow;
            done_ff <= overflow;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == sia_pkg::DIV_CNT_W'(sia_pkg::QUO_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         dsr_ff <= ctrl.divisor;
         rem_ff <= ctrl.dividend[sia_pkg::PROD_W-1:sia_pkg::QUO_W];
         quo_ff <= overflow ? '1 : ctrl.dividend[sia_pkg::QUO_W-1:0];
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[sia_pkg::HALF_W-1:0] : trial[sia_pkg::HALF_W-1:0];
         quo_ff <= {quo_ff[sia_pkg::QUO_W-2:0], fits};
      end
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

// ===== design/sia_checker.sv =====
// Port-level assertions for the salience ignition arbiter, bound to the top level.
// Depends on sia_pkg and salience_ignition_arbiter_top.

module sia_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_cmd,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_ignited,
   input logic [sia_pkg::HALF_W-1:0]   rsp_burst_left,
   input logic [sia_pkg::SAL_W-1:0]    rsp_ignition_total
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ignition_total))
      else $error("response dropped or changed while stalled");

   // a tick request occupies the sequencer
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd |=> !req_ready)
      else $error("ready stayed high after a tick request");

   // a spike request is absorbed without dropping ready
   a_spike_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_cmd |=> req_ready)
      else $error("ready dropped after a spike request");

   // broadcast flag agrees with the remaining tick count
   a_lit_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ignited == (rsp_burst_left != '0)))
      else $error("ignited flag disagrees with burst_left");

endmodule

bind salience_ignition_arbiter_top sia_checker u_sia_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .req_cmd            (req_ch.cmd),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_ignited        (rsp_ch.ignited),
   .rsp_burst_left     (rsp_ch.burst_left),
   .rsp_ignition_total (rsp_ch.ignition_total)
);

// ===== verif/tb_salience_ignition_arbiter_top.sv =====
// Self-checking testbench for salience_ignition_arbiter_top: spike and tick requests
// go in, an in-line predictor computes every tick response, and each field is checked.
// Depends on sia_pkg, sia_if and the salience_ignition_arbiter_top RTL.

module tb_salience_ignition_arbiter_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   NUM_REGIONS  = sia_pkg::NUM_REGIONS;
   localparam int   SAL_W        = sia_pkg::SAL_W;
   localparam int   REGION_W     = sia_pkg::REGION_W;
   localparam int   HALF_W       = sia_pkg::HALF_W;
   localparam int   PEND_W       = sia_pkg::PEND_W;
   localparam int   TIME_W       = sia_pkg::TIME_W;
   localparam int   CSR_IDX_W    = sia_pkg::CSR_IDX_W;
   localparam int   CSR_DATA_W   = sia_pkg::CSR_DATA_W;

   localparam logic CMD_SPIKE    = 1'b0;
   localparam logic CMD_TICK     = 1'b1;
   localparam int   DRAIN_CYCLES = 64;
   localparam int   HOLD_CYCLES  = 400;
   localparam int   MAX_REPORTS  = 100;
   localparam int   PHASE_ITEMS  = 300;
   localparam int   PENDING_BURST = 64;

   typedef struct packed {
      logic [SAL_W-1:0]    drive_level;
      logic                ignited;
      logic [REGION_W-1:0] content_region;
      logic [REGION_W-1:0] winner_region;
      logic [SAL_W-1:0]    winning_salience;
      logic [SAL_W-1:0]    ignition_total;
      logic [HALF_W-1:0]   burst_left;
   } tick_outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sia_req_if req_ch ();
   sia_rsp_if rsp_ch ();

   salience_ignition_arbiter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of registers and state
   logic [HALF_W-1:0]   cfg_decay;
   logic [HALF_W-1:0]   cfg_min_gap;
   logic [SAL_W-1:0]    cfg_threshold;
   logic [HALF_W-1:0]   cfg_burst_len;
   logic [HALF_W-1:0]   cfg_burst_gain;
   logic [SAL_W-1:0]    region_salience [NUM_REGIONS];
   logic [PEND_W-1:0]   spike_backlog   [NUM_REGIONS];
   logic                broadcast_on;
   logic [REGION_W-1:0] held_region;
   logic [HALF_W-1:0]   ticks_left;
   logic [SAL_W-1:0]    burst_peak;
   logic [TIME_W-1:0]   last_fire_time;
   logic                has_fired;
   logic [SAL_W-1:0]    fire_count;

   tick_outcome_type  expected_outcomes [$];
   int                mismatch_count = 0;
   int                send_idle_pct  = 0;
   int                rsp_stall_pct  = 0;
   bit                hold_armed     = 1'b0;
   int                hold_count     = 0;
   logic [TIME_W-1:0] tick_time      = '0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("tb_salience_ignition_arbiter_top: FAIL");
      $finish;
   end

   function automatic logic [SAL_W-1:0] clamp32(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? '1 : v[SAL_W-1:0];
   endfunction

   task automatic reset_predictor();
      cfg_decay      = 16'd58982;
      cfg_min_gap    = 16'd10;
      cfg_threshold  = 32'd5120;
      cfg_burst_len  = 16'd10;
      cfg_burst_gain = 16'd512;
      foreach (region_salience[i]) begin
         region_salience[i] = '0;
         spike_backlog[i]   = '0;
      end
      broadcast_on   = 1'b0;
      held_region    = '0;
      ticks_left     = '0;
      burst_peak     = '0;
      last_fire_time = '0;
      has_fired      = 1'b0;
      fire_count     = '0;
   endtask

   // Advances the predictor by one accepted request; ticks queue an expected response.
   task automatic update_salience(input logic cmd, input logic [REGION_W-1:0] region,
                                  input logic [TIME_W-1:0] now);
      tick_outcome_type    res;
      logic [63:0]         wide;
      logic [SAL_W-1:0]    best;
      logic [REGION_W-1:0] win;
      logic [HALF_W-1:0]   eff_len;
      logic                gap_ok;
      if (cmd == CMD_SPIKE) begin
         if (spike_backlog[region] != '1)
            spike_backlog[region]++;
         return;
      end
      best = '0;
      win  = '0;
      for (int i = 0; i < NUM_REGIONS; i++) begin
         wide = (64'(region_salience[i]) * 64'(cfg_decay)) >> 16;
         wide += 64'(spike_backlog[i]) << 8;
         region_salience[i] = clamp32(wide);
         spike_backlog[i]   = '0;
         // strict compare keeps ties on the lowest index
         if (region_salience[i] > best) begin
            best = region_salience[i];
            win  = REGION_W'(i);
         end
      end
      eff_len = (cfg_burst_len == '0) ? 16'd1 : cfg_burst_len;
      gap_ok  = !has_fired || ((now - last_fire_time) >= 32'(cfg_min_gap));
      if (!broadcast_on && gap_ok && best >= cfg_threshold) begin
         broadcast_on   = 1'b1;
         held_region    = win;
         fire_count++;
         ticks_left     = eff_len;
         last_fire_time = now;
         has_fired      = 1'b1;
         burst_peak     = clamp32((64'(best) * 64'(cfg_burst_gain)) >> 8);
      end
      res.drive_level = '0;
      if (ticks_left != '0) begin
         res.drive_level = clamp32((64'(burst_peak) * 64'(ticks_left)) / 64'(eff_len));
         ticks_left--;
         if (ticks_left == '0)
            broadcast_on = 1'b0;
      end
      res.ignited          = broadcast_on;
      res.content_region   = held_region;
      res.winner_region    = win;
      res.winning_salience = best;
      res.ignition_total   = fire_count;
      res.burst_left       = ticks_left;
      expected_outcomes.push_back(res);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t mismatch on %s: got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      tick_outcome_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("response with no tick outstanding", '0, '0);
         end else begin
            want = expected_outcomes.pop_front();
            check_field("drive_level", rsp_ch.drive_level, want.drive_level);
            check_field("ignited", rsp_ch.ignited, want.ignited);
            check_field("content_region", rsp_ch.content_region, want.content_region);
            check_field("winner_region", rsp_ch.winner_region, want.winner_region);
            check_field("winning_salience", rsp_ch.winning_salience, want.winning_salience);
            check_field("ignition_total", rsp_ch.ignition_total, want.ignition_total);
            check_field("burst_left", rsp_ch.burst_left, want.burst_left);
         end
      end
   end

   // Response ready: random stalls, or a long hold-off when armed.
   always @(negedge clock) begin
      if (hold_armed) begin
         hold_armed = 1'b0;
         hold_count = HOLD_CYCLES;
      end
      if (hold_count > 0) begin
         hold_count--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Entered and left at a falling edge; valid stays up so back-to-back requests flow.
   task automatic send_request(input logic cmd, input logic [REGION_W-1:0] region,
                               input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= cmd;
      req_ch.region_index <= region;
      req_ch.time_now     <= now;
      do
         @(posedge clock);
      while (req_ch.ready !== 1'b1);
      update_salience(cmd, region, now);
      @(negedge clock);
   endtask

   task automatic send_spike(input logic [REGION_W-1:0] region);
      send_request(CMD_SPIKE, region, $urandom);
   endtask

   task automatic send_tick(input logic [TIME_W-1:0] now);
      send_request(CMD_TICK, REGION_W'($urandom_range(NUM_REGIONS - 1)), now);
   endtask

   task automatic quiet_requests();
      req_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_until_idle();
      quiet_requests();
      while (expected_outcomes.size() != 0)
         @(negedge clock);
      // spikes return nothing, so give the last one time to settle too
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input sia_pkg::csr_index_type idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic apply_config(input logic [HALF_W-1:0] decay, input logic [HALF_W-1:0] gap,
                               input logic [SAL_W-1:0] thr, input logic [HALF_W-1:0] len,
                               input logic [HALF_W-1:0] gain);
      wait_until_idle();
      csr_write(sia_pkg::CSR_DECAY_FACTOR, 32'(decay));
      csr_write(sia_pkg::CSR_MIN_GAP_TICKS, 32'(gap));
      csr_write(sia_pkg::CSR_IGNITE_THRESHOLD, thr);
      csr_write(sia_pkg::CSR_BURST_LENGTH, 32'(len));
      csr_write(sia_pkg::CSR_BURST_GAIN, 32'(gain));
      csr_we <= 1'b0;
      cfg_decay      = decay;
      cfg_min_gap    = gap;
      cfg_threshold  = thr;
      cfg_burst_len  = len;
      cfg_burst_gain = gain;
   endtask

   task automatic finish_broadcast();
      while (ticks_left != '0) begin
         tick_time += 1;
         send_tick(tick_time);
      end
   endtask

   task automatic pick_random_config();
      logic [HALF_W-1:0] decay;
      logic [HALF_W-1:0] gap;
      logic [SAL_W-1:0]  thr;
      logic [HALF_W-1:0] len;
      logic [HALF_W-1:0] gain;
      case ($urandom_range(3))
         0: decay = '0;
         1: decay = '1;
         default: decay = HALF_W'($urandom_range(65535, 40000));
      endcase
      case ($urandom_range(5))
         0: gap = '0;
         1: gap = HALF_W'($urandom_range(65535));
         default: gap = HALF_W'($urandom_range(1, 20));
      endcase
      case ($urandom_range(5))
         0: thr = '0;
         1: thr = $urandom;
         default: thr = 32'(256 * $urandom_range(1, 40));
      endcase
      len = ($urandom_range(5) == 0) ? '0 : HALF_W'($urandom_range(1, 16));
      case ($urandom_range(3))
         0: gain = '0;
         1: gain = '1;
         default: gain = HALF_W'($urandom_range(65535));
      endcase
      apply_config(decay, gap, thr, len, gain);
   endtask

   // Register reset values: twenty spikes reach the default threshold exactly.
   task automatic test_reset_defaults();
      repeat (20) send_spike(4'd3);
      tick_time = 32'd7;
      send_tick(tick_time);
      finish_broadcast();
   endtask

   task automatic test_directed_extremes();
      // zero threshold with every region empty fires on region 0
      apply_config('0, '0, '0, '0, '1);
      send_tick(32'd0);
      // tie between regions 9 and 5 goes to 5; time at its top value
      send_spike(4'd9);
      send_spike(4'd9);
      send_spike(4'd5);
      send_spike(4'd5);
      send_tick(32'hFFFF_FFFF);
      repeat (3) send_spike(4'd15);
      send_tick(32'd0);
      apply_config('1, '1, '1, '1, '0);
      send_spike(4'd10);
      send_tick(32'd12345);
      // minimum gap one short, exactly met, then met across the time wrap
      apply_config('0, '1, '0, 16'd1, 16'd256);
      send_tick(last_fire_time + 32'd65534);
      send_tick(last_fire_time + 32'd65535);
      send_tick(last_fire_time - 32'd1);
   endtask

   // A run of spikes on one region folds into a single tick and ignites.
   task automatic test_pending_count();
      apply_config('1, '0, 32'd1, 16'd3, '1);
      finish_broadcast();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (PENDING_BURST) send_spike(4'd12);
      tick_time += 1;
      send_tick(tick_time);
   endtask

   // Broadcast started above with length 3; shrink the length while it runs.
   task automatic test_length_change();
      apply_config('1, '0, 32'd1, 16'd1, '1);
      tick_time += 1;
      send_tick(tick_time);
      apply_config('1, '0, 32'd1, '0, '1);
      tick_time += 1;
      send_tick(tick_time);
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_armed    = 1'b1;
      repeat (6) begin
         repeat (3) send_spike(REGION_W'($urandom_range(NUM_REGIONS - 1)));
         tick_time += 3;
         send_tick(tick_time);
      end
      quiet_requests();
      while (hold_armed || hold_count > 0)
         @(negedge clock);
   endtask

   task automatic run_random_traffic(input int n_items);
      int                  sent;
      int                  spikes;
      logic [REGION_W-1:0] favored;
      sent = 0;
      while (sent < n_items) begin
         favored = REGION_W'($urandom_range(NUM_REGIONS - 1));
         spikes  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
         repeat (spikes) begin
            if ($urandom_range(3) == 0)
               send_spike(REGION_W'($urandom_range(NUM_REGIONS - 1)));
            else
               send_spike(favored);
            sent++;
         end
         // mostly small steps; now and then time jumps anywhere, backwards included
         if ($urandom_range(9) == 0)
            tick_time = $urandom;
         else
            tick_time += $urandom_range(12);
         send_tick(tick_time);
         sent++;
      end
   endtask

   task automatic test_random_phases();
      int idle_set  [4] = '{0, 72, 0, 32};
      int stall_set [4] = '{0, 0, 72, 32};
      for (int p = 0; p < 4; p++) begin
         pick_random_config();
         send_idle_pct = idle_set[p];
         rsp_stall_pct = stall_set[p];
         run_random_traffic(PHASE_ITEMS);
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.cmd          = CMD_SPIKE;
      req_ch.region_index = '0;
      req_ch.time_now     = '0;
      rsp_ch.ready        = 1'b0;
      reset_predictor();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_extremes();
      test_pending_count();
      test_length_change();
      test_output_backpressure();
      test_random_phases();

      wait_until_idle();
      if (mismatch_count == 0)
         $display("tb_salience_ignition_arbiter_top: PASS");
      else
         $display("tb_salience_ignition_arbiter_top: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/sia_pkg.sv
design/sia_if.sv
design/sia_divider.sv
design/salience_ignition_arbiter_top.sv
design/sia_checker.sv
verif/tb_salience_ignition_arbiter_top.sv
